### hdl/xxh64_pkg.sv
package xxh64_pkg;

    localparam int WORD_W    = 64;
    localparam int HALF_W    = 32;
    localparam int VB_W      = 4;
    localparam int S_TDATA_W = 72;
    localparam int REM_W     = 3;
    localparam int FILL_W    = 3;
    localparam int IDX_W     = 2;
    localparam int LANE_CNT  = 4;

    localparam logic [FILL_W-1:0] FILL_FULL       = 3'd4;
    localparam logic [IDX_W-1:0]  LAST_IDX        = 2'd3;
    localparam logic [VB_W-1:0]   FULL_WORD_BYTES = 4'd8;

    localparam logic [WORD_W-1:0] PRIME1 = 64'h9E3779B185EBCA87;
    localparam logic [WORD_W-1:0] PRIME2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [WORD_W-1:0] PRIME3 = 64'h165667B19E3779F9;
    localparam logic [WORD_W-1:0] PRIME4 = 64'h85EBCA77C2B2AE63;
    localparam logic [WORD_W-1:0] PRIME5 = 64'h27D4EB2F165667C5;

    // Datapath operations. The first group needs no multiply, the
    // second group runs one 64-bit multiply on the shared multiplier.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_LANE_INIT,
        OP_STRIPE_END,
        OP_MERGE_START,
        OP_SEED_START,
        OP_ADD_LEN,
        OP_OUT_LOAD,
        OP_LANE_A,
        OP_LANE_B,
        OP_KA_LANE,
        OP_KA_WORD,
        OP_K_B,
        OP_MERGE_H,
        OP_FILL_H,
        OP_W4_A,
        OP_W4_B,
        OP_B1_A,
        OP_B1_B,
        OP_AV1,
        OP_AV2
    } op_t;

    typedef struct packed {
        op_t              op;
        logic             go;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic              seen;
        logic              last;
        logic [REM_W-1:0]  rem;
        logic              mul_done;
    } stat_t;

    function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] v,
                                                 input int unsigned n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    function automatic logic is_mul_op(input op_t op);
        logic r;
        case (op) inside
            OP_LANE_A, OP_LANE_B, OP_KA_LANE, OP_KA_WORD, OP_K_B, OP_MERGE_H,
            OP_FILL_H, OP_W4_A, OP_W4_B, OP_B1_A, OP_B1_B, OP_AV1, OP_AV2: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

### hdl/xxh64_mul.sv
module xxh64_mul
    import xxh64_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [WORD_W-1:0] a,
    input  logic [WORD_W-1:0] b,
    output logic              busy,
    output logic              done,
    output logic [WORD_W-1:0] product
);

    // Low 64 bits of a*b from three 32x32 partial products, one per cycle.
    localparam logic [1:0] PH_LL = 2'd0;
    localparam logic [1:0] PH_LH = 2'd1;
    localparam logic [1:0] PH_HL = 2'd2;

    logic              busy_reg;
    logic              done_reg;
    logic [1:0]        phase_reg;
    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] b_reg;
    logic [WORD_W-1:0] acc_reg;
    logic [WORD_W-1:0] acc_next;
    logic [HALF_W-1:0] x;
    logic [HALF_W-1:0] y;
    logic [WORD_W-1:0] pp;

    always_comb begin
        case (phase_reg)
            PH_LL: begin
                x = a_reg[HALF_W-1:0];
                y = b_reg[HALF_W-1:0];
            end
            PH_LH: begin
                x = a_reg[HALF_W-1:0];
                y = b_reg[WORD_W-1:HALF_W];
            end
            default: begin
                x = a_reg[WORD_W-1:HALF_W];
                y = b_reg[HALF_W-1:0];
            end
        endcase
        pp = WORD_W'(x) * WORD_W'(y);
        if (phase_reg == PH_LL) begin
            acc_next = pp;
        end else begin
            acc_next = acc_reg + {pp[HALF_W-1:0], {HALF_W{1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= PH_LL;
        end else begin
            done_reg <= busy_reg && (phase_reg == PH_HL);
            if (start) begin
                busy_reg  <= 1'b1;
                phase_reg <= PH_LL;
                a_reg     <= a;
                b_reg     <= b;
            end else if (busy_reg) begin
                acc_reg <= acc_next;
                if (phase_reg == PH_HL) begin
                    busy_reg <= 1'b0;
                end else begin
                    phase_reg <= phase_reg + 2'd1;
                end
            end
        end
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = acc_reg;

endmodule

### hdl/xxh64_dp.sv
module xxh64_dp
    import xxh64_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [WORD_W-1:0] cfg_wdata,
    input  logic [WORD_W-1:0] in_word,
    input  logic [VB_W-1:0]   in_vb,
    input  logic              in_last,
    input  cmd_t              cmd,
    output stat_t             stat,
    output logic [WORD_W-1:0] hash
);

    logic [WORD_W-1:0] seed_reg;
    logic [WORD_W-1:0] lane_reg   [LANE_CNT];
    logic [WORD_W-1:0] stripe_reg [LANE_CNT];
    logic [FILL_W-1:0] fill_reg;
    logic [WORD_W-1:0] total_reg;
    logic              seen_reg;
    logic              last_reg;
    logic [WORD_W-1:0] tail_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [WORD_W-1:0] h_reg;
    logic [WORD_W-1:0] t_reg;
    logic [WORD_W-1:0] hash_reg;
    op_t               mop_reg;
    logic [IDX_W-1:0]  midx_reg;

    logic [VB_W-1:0]   vb_sat;
    logic              push;
    logic [REM_W-1:0]  acc_rem;
    logic [WORD_W-1:0] merge_sum;
    logic [WORD_W-1:0] mul_a;
    logic [WORD_W-1:0] mul_b;
    logic              mul_start;
    logic              mul_busy;
    logic              mul_done;
    logic [WORD_W-1:0] mul_p;

    // A word that is not last always counts as eight bytes.
    always_comb begin
        if (!in_last) begin
            vb_sat = FULL_WORD_BYTES;
        end else if (in_vb > FULL_WORD_BYTES) begin
            vb_sat = FULL_WORD_BYTES;
        end else begin
            vb_sat = in_vb;
        end
        push    = vb_sat[VB_W-1];
        acc_rem = push ? '0 : vb_sat[REM_W-1:0];
    end

    assign merge_sum = rotl64(lane_reg[0], 1) + rotl64(lane_reg[1], 7) +
                       rotl64(lane_reg[2], 12) + rotl64(lane_reg[3], 18);

    assign mul_start = cmd.go && is_mul_op(cmd.op);

    always_comb begin
        unique case (cmd.op) inside
            OP_LANE_A, OP_KA_WORD: begin
                mul_a = stripe_reg[cmd.idx];
                mul_b = PRIME2;
            end
            OP_KA_LANE: begin
                mul_a = lane_reg[cmd.idx];
                mul_b = PRIME2;
            end
            OP_LANE_B, OP_K_B: begin
                mul_a = t_reg;
                mul_b = PRIME1;
            end
            OP_MERGE_H: begin
                mul_a = h_reg ^ t_reg;
                mul_b = PRIME1;
            end
            OP_FILL_H: begin
                mul_a = rotl64(h_reg ^ t_reg, 27);
                mul_b = PRIME1;
            end
            OP_W4_A: begin
                mul_a = {{(WORD_W-HALF_W){1'b0}}, tail_reg[HALF_W-1:0]};
                mul_b = PRIME1;
            end
            OP_W4_B: begin
                mul_a = rotl64(h_reg ^ t_reg, 23);
                mul_b = PRIME2;
            end
            OP_B1_A: begin
                mul_a = {{(WORD_W-8){1'b0}}, tail_reg[7:0]};
                mul_b = PRIME5;
            end
            OP_B1_B: begin
                mul_a = rotl64(h_reg ^ t_reg, 11);
                mul_b = PRIME1;
            end
            OP_AV1: begin
                mul_a = h_reg ^ (h_reg >> 33);
                mul_b = PRIME2;
            end
            OP_AV2: begin
                mul_a = h_reg ^ (h_reg >> 29);
                mul_b = PRIME3;
            end
            default: begin
                mul_a = h_reg;
                mul_b = PRIME1;
            end
        endcase
    end

    xxh64_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (mul_p)
    );

    // Message bookkeeping and the seed register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg  <= '0;
            fill_reg  <= '0;
            total_reg <= '0;
            seen_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                seed_reg <= cfg_wdata;
            end
            if (cmd.go) begin
                unique case (cmd.op)
                    OP_ACCEPT: begin
                        total_reg <= total_reg + {{(WORD_W-VB_W){1'b0}}, vb_sat};
                        last_reg  <= in_last;
                        if (push) begin
                            fill_reg <= fill_reg + 3'd1;
                        end
                    end
                    OP_STRIPE_END: begin
                        seen_reg <= 1'b1;
                        fill_reg <= '0;
                    end
                    OP_OUT_LOAD: begin
                        seen_reg  <= 1'b0;
                        fill_reg  <= '0;
                        total_reg <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Hash state, stripe buffer and multiply write-back.
    always_ff @(posedge aclk) begin
        if (mul_start) begin
            mop_reg  <= cmd.op;
            midx_reg <= cmd.idx;
        end
        if (cmd.go) begin
            unique case (cmd.op)
                OP_ACCEPT: begin
                    tail_reg <= in_word;
                    rem_reg  <= acc_rem;
                    if (push) begin
                        stripe_reg[fill_reg[IDX_W-1:0]] <= in_word;
                    end
                end
                OP_LANE_INIT: begin
                    lane_reg[0] <= seed_reg + PRIME1 + PRIME2;
                    lane_reg[1] <= seed_reg + PRIME2;
                    lane_reg[2] <= seed_reg;
                    lane_reg[3] <= seed_reg - PRIME1;
                end
                OP_MERGE_START: h_reg    <= merge_sum;
                OP_SEED_START:  h_reg    <= seed_reg + PRIME5;
                OP_ADD_LEN:     h_reg    <= h_reg + total_reg;
                OP_OUT_LOAD:    hash_reg <= h_reg ^ (h_reg >> 32);
                default: ;
            endcase
        end
        if (mul_done) begin
            unique case (mop_reg) inside
                OP_LANE_A: t_reg <= rotl64(lane_reg[midx_reg] + mul_p, 31);
                OP_LANE_B: lane_reg[midx_reg] <= mul_p;
                OP_KA_LANE, OP_KA_WORD: t_reg <= rotl64(mul_p, 31);
                OP_K_B, OP_W4_A, OP_B1_A: t_reg <= mul_p;
                OP_MERGE_H, OP_FILL_H: h_reg <= mul_p + PRIME4;
                OP_W4_B: begin
                    h_reg    <= mul_p + PRIME3;
                    tail_reg <= tail_reg >> 32;
                    rem_reg  <= rem_reg - 3'd4;
                end
                OP_B1_B: begin
                    h_reg    <= mul_p;
                    tail_reg <= tail_reg >> 8;
                    rem_reg  <= rem_reg - 3'd1;
                end
                OP_AV1, OP_AV2: h_reg <= mul_p;
                default: ;
            endcase
        end
    end

    assign stat.fill     = fill_reg;
    assign stat.seen     = seen_reg;
    assign stat.last     = last_reg;
    assign stat.rem      = rem_reg;
    assign stat.mul_done = mul_done;
    assign hash          = hash_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_FULL)
        else $error("stripe fill count beyond four words");

    a_no_accept_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.go && cmd.op == OP_ACCEPT) |-> (fill_reg != FILL_FULL))
        else $error("word accepted before full stripe was consumed");

    a_mul_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |-> (!mul_busy && !mul_done))
        else $error("multiply started while previous one in flight");

endmodule

### hdl/xxh64_ctrl.sv
module xxh64_ctrl
    import xxh64_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_INIT,
        S_LANE_A,
        S_LANE_B,
        S_STRIPE_END,
        S_FIN,
        S_MRG_KA,
        S_MRG_KB,
        S_MRG_H,
        S_ADD_LEN,
        S_FILL_KA,
        S_FILL_KB,
        S_FILL_H,
        S_TAIL,
        S_W4_A,
        S_W4_B,
        S_B1_A,
        S_B1_B,
        S_AV1,
        S_AV2,
        S_OUT
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic             wait_reg;
    logic             wait_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             step_done;
    op_t              cmd_op;
    logic             cmd_go;

    assign step_done = wait_reg && stat.mul_done;

    always_comb begin
        state_next     = state_reg;
        wait_next      = wait_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd_op         = OP_NONE;
        cmd_go         = 1'b0;
        in_ready       = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd_op     = OP_ACCEPT;
                    cmd_go     = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (stat.fill == FILL_FULL) begin
                    idx_next   = '0;
                    state_next = stat.seen ? S_LANE_A : S_INIT;
                end else if (stat.last) begin
                    state_next = S_FIN;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_INIT: begin
                cmd_op     = OP_LANE_INIT;
                cmd_go     = 1'b1;
                state_next = S_LANE_A;
            end
            S_LANE_A: begin
                cmd_op = OP_LANE_A;
                if (step_done) begin
                    state_next = S_LANE_B;
                end
            end
            S_LANE_B: begin
                cmd_op = OP_LANE_B;
                if (step_done) begin
                    if (idx_reg == LAST_IDX) begin
                        state_next = S_STRIPE_END;
                    end else begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = S_LANE_A;
                    end
                end
            end
            S_STRIPE_END: begin
                cmd_op     = OP_STRIPE_END;
                cmd_go     = 1'b1;
                state_next = stat.last ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                idx_next = '0;
                cmd_go   = 1'b1;
                if (stat.seen) begin
                    cmd_op     = OP_MERGE_START;
                    state_next = S_MRG_KA;
                end else begin
                    cmd_op     = OP_SEED_START;
                    state_next = S_ADD_LEN;
                end
            end
            S_MRG_KA: begin
                cmd_op = OP_KA_LANE;
                if (step_done) begin
                    state_next = S_MRG_KB;
                end
            end
            S_MRG_KB: begin
                cmd_op = OP_K_B;
                if (step_done) begin
                    state_next = S_MRG_H;
                end
            end
            S_MRG_H: begin
                cmd_op = OP_MERGE_H;
                if (step_done) begin
                    if (idx_reg == LAST_IDX) begin
                        state_next = S_ADD_LEN;
                    end else begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = S_MRG_KA;
                    end
                end
            end
            S_ADD_LEN: begin
                cmd_op     = OP_ADD_LEN;
                cmd_go     = 1'b1;
                idx_next   = '0;
                state_next = (stat.fill != '0) ? S_FILL_KA : S_TAIL;
            end
            S_FILL_KA: begin
                cmd_op = OP_KA_WORD;
                if (step_done) begin
                    state_next = S_FILL_KB;
                end
            end
            S_FILL_KB: begin
                cmd_op = OP_K_B;
                if (step_done) begin
                    state_next = S_FILL_H;
                end
            end
            S_FILL_H: begin
                cmd_op = OP_FILL_H;
                if (step_done) begin
                    if (({1'b0, idx_reg} + 3'd1) == stat.fill) begin
                        state_next = S_TAIL;
                    end else begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = S_FILL_KA;
                    end
                end
            end
            S_TAIL: begin
                if (stat.rem[REM_W-1]) begin
                    state_next = S_W4_A;
                end else if (stat.rem != '0) begin
                    state_next = S_B1_A;
                end else begin
                    state_next = S_AV1;
                end
            end
            S_W4_A: begin
                cmd_op = OP_W4_A;
                if (step_done) begin
                    state_next = S_W4_B;
                end
            end
            S_W4_B: begin
                cmd_op = OP_W4_B;
                if (step_done) begin
                    state_next = S_TAIL;
                end
            end
            S_B1_A: begin
                cmd_op = OP_B1_A;
                if (step_done) begin
                    state_next = S_B1_B;
                end
            end
            S_B1_B: begin
                cmd_op = OP_B1_B;
                if (step_done) begin
                    state_next = S_TAIL;
                end
            end
            S_AV1: begin
                cmd_op = OP_AV1;
                if (step_done) begin
                    state_next = S_AV2;
                end
            end
            S_AV2: begin
                cmd_op = OP_AV2;
                if (step_done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!out_valid_reg || out_ready) begin
                    cmd_op         = OP_OUT_LOAD;
                    cmd_go         = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Multiply steps: issue once on entry, then hold until the product lands.
        if (is_mul_op(cmd_op)) begin
            cmd_go    = !wait_reg;
            wait_next = !step_done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            wait_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wait_reg      <= wait_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign cmd.op    = cmd_op;
    assign cmd.go    = cmd_go;
    assign cmd.idx   = idx_reg;
    assign out_valid = out_valid_reg;

    a_ready_not_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready |-> !wait_reg)
        else $error("input ready while a multiply is outstanding");

    a_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.mul_done |-> wait_reg)
        else $error("multiply completed with no step waiting on it");

    a_load_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_go && cmd_op == OP_OUT_LOAD) |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken result");

endmodule

### hdl/xxhash64_stream_hasher_unit.sv
// Streaming XXH64 hasher. Message bytes arrive as little-endian 64-bit words,
// first byte in bits 7:0, one word per input transaction; tlast marks the final
// word, and only that word may carry fewer than eight valid bytes (0 to 8, larger
// counts are treated as 8). One result transaction carries the 64-bit hash after
// each final word. The seed is written through cfg_we/cfg_wdata and resets to zero;
// the user must write it only while the block is idle, the block does not enforce it.
// Every 64-bit multiply runs on one shared 32x32 multiplier in three partial
// products. A word that completes a 32-byte stripe runs the four lane rounds
// (the first stripe of a message also loads the lanes from the seed), and the
// block takes no new word until it is through with the last one. The final word
// then runs the lane merge (only if a stripe was seen), adds the length, and runs
// one round per buffered full word, one for a 4-byte tail, one per remaining
// byte, and the avalanche.
// A finished hash sits in an output register, so the next message can start while
// the previous hash waits to be taken.
module xxhash64_stream_hasher_unit
    import xxh64_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    // Seed register write.
    input  logic                 cfg_we,
    input  logic [WORD_W-1:0]    cfg_wdata,

    // Message words.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [63:0] data_word, [67:64] valid_bytes, [71:68] zero
    input  logic                 s_tlast,

    // Hash results.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [WORD_W-1:0]    m_tdata    // [63:0] hash_value
);

    cmd_t  cmd;
    stat_t stat;

    // The controller sequences every step of the algorithm; the datapath holds
    // the lanes, the stripe buffer, the length counter and the multiplier, and
    // apart from seed writes only acts on the command it is given in each cycle.
    xxh64_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath captures the input word only when the controller accepts a
    // transaction, so the data fields are taken straight from the port.
    xxh64_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_word   (s_tdata[WORD_W-1:0]),
        .in_vb     (s_tdata[WORD_W+VB_W-1:WORD_W]),
        .in_last   (s_tlast),
        .cmd       (cmd),
        .stat      (stat),
        .hash      (m_tdata)
    );

endmodule
